/* hw/rtl/nsfd_pkg.sv */
// ----------------------------------------------------------------------------
// nsfd_pkg
// Shared types and constants for the nibble split frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfd_pkg;

	localparam int MAX_DECODED = 1024;
	localparam int LEN_W       = 11;
	localparam int CNT_W       = 32;

	localparam logic [7:0] BYTE_START  = 8'h2A;
	localparam logic [7:0] BYTE_END    = 8'h3B;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(MAX_DECODED);

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_END_OK   = 3'd1,
		KIND_RESTART  = 3'd2,
		KIND_ODD      = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

endpackage

`default_nettype wire

/* hw/rtl/nibble_split_frame_decoder.sv */
// ----------------------------------------------------------------------------
// nibble_split_frame_decoder
// Frame hunter and nibble pair decoder for raw link bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte): one raw link byte per request.
//   Output channel (out_valid/out_ready): kind, data_byte, dec_len,
//   frame_last, good_count, bad_count. At most one result per input byte.
//   Config channel (cfg_valid/cfg_ready, cfg_data): max_decoded_len, always
//   ready; write only while the block is idle.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled. Frame state is updated by a
//   single pass of logic on accept and the result goes to one output register.
// Stall: while the output register holds an untaken result, in_ready follows
//   out_ready, so a byte is still taken in the cycle the result leaves.
// Reset: arst_n clears frame state, both totals and out_valid, but not the
//   output data fields; max_decoded_len returns to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_split_frame_decoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [nsfd_pkg::LEN_W-1:0]   cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [7:0]                   rx_byte,
	output logic                         out_valid,
	input  wire                          out_ready,
	output nsfd_pkg::kind_t              kind,
	output logic [7:0]                   data_byte,
	output logic [nsfd_pkg::LEN_W-1:0]   dec_len,
	output logic                         frame_last,
	output logic [nsfd_pkg::CNT_W-1:0]   good_count,
	output logic [nsfd_pkg::CNT_W-1:0]   bad_count
);

	import nsfd_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	logic             in_frame_q;
	logic             half_q;
	logic [3:0]       high_nib_q;
	logic [LEN_W-1:0] raw_count_q;
	logic [CNT_W-1:0] good_total_q;
	logic [CNT_W-1:0] bad_total_q;

	logic             in_fire;
	logic [LEN_W-1:0] limit;
	logic [LEN_W:0]   frame_raw;

	logic             in_frame_d;
	logic             half_d;
	logic [3:0]       high_nib_d;
	logic [LEN_W-1:0] raw_count_d;
	logic [CNT_W-1:0] good_total_d;
	logic [CNT_W-1:0] bad_total_d;
	logic             res_valid;
	kind_t            res_kind;
	logic [7:0]       res_data;
	logic [LEN_W-1:0] res_len;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;

	assign limit     = (max_len_q > MAX_LEN_RESET) ? MAX_LEN_RESET : max_len_q;
	// start byte + payload bytes held
	assign frame_raw = (LEN_W+1)'({raw_count_q, half_q}) + (LEN_W+1)'(1);

	always_comb begin
		in_frame_d   = in_frame_q;
		half_d       = half_q;
		high_nib_d   = high_nib_q;
		raw_count_d  = raw_count_q;
		good_total_d = good_total_q;
		bad_total_d  = bad_total_q;
		res_valid    = 1'b0;
		res_kind     = KIND_DATA;
		res_data     = 8'h00;
		res_len      = raw_count_q;
		if (!in_frame_q) begin
			if (rx_byte == BYTE_START) begin
				in_frame_d  = 1'b1;
				half_d      = 1'b0;
				high_nib_d  = 4'h0;
				raw_count_d = '0;
			end else begin
				bad_total_d = bad_total_q + CNT_W'(1);
			end
		end else if (rx_byte == BYTE_START) begin
			bad_total_d = bad_total_q + CNT_W'(frame_raw);
			half_d      = 1'b0;
			high_nib_d  = 4'h0;
			raw_count_d = '0;
			res_valid   = 1'b1;
			res_kind    = KIND_RESTART;
		end else if (rx_byte == BYTE_END) begin
			if (half_q) begin
				bad_total_d = bad_total_q + CNT_W'(frame_raw) + CNT_W'(1);
				res_kind    = KIND_ODD;
			end else begin
				good_total_d = good_total_q + CNT_W'(frame_raw) + CNT_W'(1);
				res_kind     = KIND_END_OK;
			end
			in_frame_d  = 1'b0;
			half_d      = 1'b0;
			high_nib_d  = 4'h0;
			raw_count_d = '0;
			res_valid   = 1'b1;
		end else if (!half_q) begin
			high_nib_d = rx_byte[3:0] & NIBBLE_MASK;
			half_d     = 1'b1;
		end else if (raw_count_q >= limit) begin
			bad_total_d = bad_total_q + CNT_W'(frame_raw) + CNT_W'(1);
			in_frame_d  = 1'b0;
			half_d      = 1'b0;
			high_nib_d  = 4'h0;
			raw_count_d = '0;
			res_valid   = 1'b1;
			res_kind    = KIND_OVERFLOW;
		end else begin
			raw_count_d = raw_count_q + LEN_W'(1);
			half_d      = 1'b0;
			res_valid   = 1'b1;
			res_kind    = KIND_DATA;
			res_data    = {high_nib_q, rx_byte[3:0] & NIBBLE_MASK};
			res_len     = raw_count_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= MAX_LEN_RESET;
			in_frame_q   <= 1'b0;
			half_q       <= 1'b0;
			high_nib_q   <= 4'h0;
			raw_count_q  <= '0;
			good_total_q <= '0;
			bad_total_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			if (in_fire) begin
				in_frame_q   <= in_frame_d;
				half_q       <= half_d;
				high_nib_q   <= high_nib_d;
				raw_count_q  <= raw_count_d;
				good_total_q <= good_total_d;
				bad_total_q  <= bad_total_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			kind       <= res_kind;
			data_byte  <= res_data;
			dec_len    <= res_len;
			frame_last <= (res_kind != KIND_DATA);
			good_count <= good_total_d;
			bad_count  <= bad_total_d;
		end
	end

	// checks
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_last == (kind != KIND_DATA)))
		else $error("frame_last does not match kind");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DATA) |-> (dec_len != '0))
		else $error("data result with zero frame length");

	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !in_frame_q && rx_byte == BYTE_START) |=> in_frame_q)
		else $error("start byte did not open a frame");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (raw_count_q == '0 && !half_q))
		else $error("frame state left over outside a frame");

endmodule

`default_nettype wire
